[rtl/bpge_pkg.sv]
// Shared types, constants and tables for the Bezier patch grid evaluator.
// No dependencies; used by bpge_ctrl, bpge_dp and the top level.
package bpge_pkg;

  localparam int unsigned MAX_SIDE   = 8;
  localparam int unsigned SIDE_W     = 3;
  localparam int unsigned ADDR_W     = 6;
  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DIV_STEPS  = 23;
  localparam int unsigned CNT_W      = 5;
  localparam logic [15:0] ONE_Q15    = 16'h8000;

  // opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_COLS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_RES  = 2'd2;

  // binomial coefficients C(n,i), row n
  localparam logic [5:0] BINOM [MAX_SIDE][MAX_SIDE] = '{
    '{6'd1, 6'd0, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd1, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd2, 6'd1,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd3, 6'd3,  6'd1,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd4, 6'd6,  6'd4,  6'd1,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd5, 6'd10, 6'd10, 6'd5,  6'd1,  6'd0, 6'd0},
    '{6'd1, 6'd6, 6'd15, 6'd20, 6'd15, 6'd6,  6'd1, 6'd0},
    '{6'd1, 6'd7, 6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1}
  };

  // controller to datapath commands
  typedef struct packed {
    logic              load;
    logic              start;
    logic              div_step;
    logic              pow_step;
    logic [SIDE_W-1:0] pow_k;
    logic              wgt_step;
    logic [3:0]        wgt_i;
    logic              acc_issue;
    logic [SIDE_W-1:0] acc_i;
    logic [SIDE_W-1:0] acc_j;
    logic [ADDR_W-1:0] acc_addr;
    logic              finish;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic              range_err;
    logic [SIDE_W-1:0] ncol;
    logic [SIDE_W-1:0] nrow;
  } stat_t;

endpackage

[rtl/bpge_ctrl.sv]
// Sequencer for the Bezier patch evaluator: division, powers, weights, sum.
// Depends on bpge_pkg; drives bpge_dp through cmd_t.
module bpge_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_opcode,
  output logic           out_valid,
  input  logic           out_ready,
  input  bpge_pkg::stat_t stat,
  output bpge_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_POW, S_WGT, S_ACC, S_DRAIN, S_FIN} state_t;

  state_t                       state_r;
  logic [bpge_pkg::CNT_W-1:0]   cnt_r;
  logic [bpge_pkg::SIDE_W-1:0]  ai_r, aj_r;
  logic [bpge_pkg::ADDR_W-1:0]  addr_r;
  logic                         out_valid_r;
  logic                         acc_last;
  logic                         fin_go;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign acc_last  = (ai_r == stat.ncol) && (aj_r == stat.nrow);
  assign fin_go    = (state_r == S_FIN) && (!out_valid_r || out_ready);

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.pow_k     = cnt_r[bpge_pkg::SIDE_W-1:0];
    cmd.wgt_i     = cnt_r[3:0];
    cmd.acc_i     = ai_r;
    cmd.acc_j     = aj_r;
    cmd.acc_addr  = addr_r;
    cmd.load      = (state_r == S_IDLE) && in_valid && (in_opcode == bpge_pkg::OP_LOAD);
    cmd.start     = (state_r == S_IDLE) && in_valid && (in_opcode == bpge_pkg::OP_EVAL);
    cmd.div_step  = (state_r == S_DIV);
    cmd.pow_step  = (state_r == S_POW);
    cmd.wgt_step  = (state_r == S_WGT);
    cmd.acc_issue = (state_r == S_ACC);
    cmd.finish    = fin_go;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ai_r        <= '0;
      aj_r        <= '0;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (cmd.start) begin
            state_r <= stat.range_err ? S_FIN : S_DIV;
          end
        end
        S_DIV: begin
          if (cnt_r == bpge_pkg::CNT_W'(bpge_pkg::DIV_STEPS - 1)) begin
            cnt_r   <= bpge_pkg::CNT_W'(1);
            state_r <= S_POW;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_POW: begin
          if (cnt_r == bpge_pkg::CNT_W'(bpge_pkg::MAX_SIDE - 1)) begin
            cnt_r   <= '0;
            state_r <= S_WGT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_WGT: begin
          if (cnt_r == bpge_pkg::CNT_W'(bpge_pkg::MAX_SIDE)) begin
            cnt_r   <= '0;
            ai_r    <= '0;
            aj_r    <= '0;
            addr_r  <= '0;
            state_r <= S_ACC;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_ACC: begin
          addr_r <= addr_r + 1'b1;
          if (acc_last) begin
            state_r <= S_DRAIN;
          end else if (ai_r == stat.ncol) begin
            ai_r <= '0;
            aj_r <= aj_r + 1'b1;
          end else begin
            ai_r <= ai_r + 1'b1;
          end
        end
        S_DRAIN: begin
          if (cnt_r == bpge_pkg::CNT_W'(2)) begin
            state_r <= S_FIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_fin_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r) else $error("finish did not raise out_valid");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r) else $error("result dropped on stall");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start || cmd.load) |-> !out_valid_r || (state_r == S_IDLE))
    else $error("accept outside idle");
  a_fin_not_acc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_issue |-> !cmd.finish) else $error("finish during accumulation");

endmodule

[rtl/bpge_dp.sv]
// Datapath: config registers, control point store, dividers, weight units,
// multiply-accumulate pipeline and result register. Depends on bpge_pkg.
module bpge_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  bpge_pkg::cmd_t      cmd,
  output bpge_pkg::stat_t     stat,
  input  logic                cfg_write_en,
  input  logic [1:0]          cfg_index,
  input  logic [8:0]          cfg_data,
  input  logic [5:0]          in_point_index,
  input  logic signed [15:0]  in_ctrl_x,
  input  logic signed [15:0]  in_ctrl_y,
  input  logic [7:0]          in_grid_u,
  input  logic [7:0]          in_grid_v,
  output logic signed [15:0]  out_vertex_x,
  output logic signed [15:0]  out_vertex_y,
  output logic [15:0]         out_tex_u,
  output logic [15:0]         out_tex_v,
  output logic                out_status
);

  localparam int unsigned SW = bpge_pkg::SIDE_W;

  // config registers and clamps
  logic [3:0] cols_r, rows_r;
  logic [8:0] res_r;
  logic [3:0] cols_c, rows_c;
  logic [8:0] res_c;
  logic [7:0] dvs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 4'd2;
      rows_r <= 4'd2;
      res_r  <= 9'd4;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        bpge_pkg::REG_COLS: cols_r <= cfg_data[3:0];
        bpge_pkg::REG_ROWS: rows_r <= cfg_data[3:0];
        bpge_pkg::REG_RES:  res_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cols_c = (cols_r < 4'd2) ? 4'd2 : (cols_r > 4'd8) ? 4'd8 : cols_r;
    rows_c = (rows_r < 4'd2) ? 4'd2 : (rows_r > 4'd8) ? 4'd8 : rows_r;
    res_c  = (res_r < 9'd4) ? 9'd4 : (res_r > 9'd256) ? 9'd256 : res_r;
    dvs    = 8'(res_c - 9'd1);
  end

  assign stat.ncol      = SW'(cols_c - 4'd1);
  assign stat.nrow      = SW'(rows_c - 4'd1);
  assign stat.range_err = ({1'b0, in_grid_u} >= res_c) || ({1'b0, in_grid_v} >= res_c);

  // control point store, y in upper half
  logic [31:0] mem [bpge_pkg::DEPTH];
  logic [31:0] mem_q_r;
  logic        load_ok;
  logic [7:0]  patch_size;

  assign patch_size = 8'(cols_c * rows_c);
  assign load_ok    = {2'b00, in_point_index} < patch_size;

  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      mem[in_point_index] <= {in_ctrl_y, in_ctrl_x};
    end
    if (cmd.acc_issue) begin
      mem_q_r <= mem[cmd.acc_addr];
    end
  end

  // restoring dividers for u and v, one quotient bit per cycle
  logic [22:0] nq_u_r, nq_v_r;
  logic [7:0]  rem_u_r, rem_v_r;
  logic [8:0]  tr_u, tr_v;
  logic        ge_u, ge_v;

  always_comb begin
    tr_u = {rem_u_r, nq_u_r[22]};
    tr_v = {rem_v_r, nq_v_r[22]};
    ge_u = tr_u >= {1'b0, dvs};
    ge_v = tr_v >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      nq_u_r  <= {in_grid_u, 15'(dvs[7:1])};
      nq_v_r  <= {in_grid_v, 15'(dvs[7:1])};
      rem_u_r <= '0;
      rem_v_r <= '0;
    end else if (cmd.div_step) begin
      rem_u_r <= ge_u ? 8'(tr_u - {1'b0, dvs}) : tr_u[7:0];
      rem_v_r <= ge_v ? 8'(tr_v - {1'b0, dvs}) : tr_v[7:0];
      nq_u_r  <= {nq_u_r[21:0], ge_u};
      nq_v_r  <= {nq_v_r[21:0], ge_v};
    end
  end

  logic [15:0] tu, tv;
  assign tu = nq_u_r[15:0];
  assign tv = nq_v_r[15:0];

  // powers of t and (1-t), rounded Q1.15 multiplies
  logic [15:0] pu [bpge_pkg::MAX_SIDE];
  logic [15:0] qu [bpge_pkg::MAX_SIDE];
  logic [15:0] pv [bpge_pkg::MAX_SIDE];
  logic [15:0] qv [bpge_pkg::MAX_SIDE];
  logic [SW-1:0] km1;
  logic [32:0]   m_pu, m_qu, m_pv, m_qv;

  assign km1  = cmd.pow_k - 1'b1;
  assign m_pu = 33'(pu[km1] * tu) + 33'd16384;
  assign m_qu = 33'(qu[km1] * (bpge_pkg::ONE_Q15 - tu)) + 33'd16384;
  assign m_pv = 33'(pv[km1] * tv) + 33'd16384;
  assign m_qv = 33'(qv[km1] * (bpge_pkg::ONE_Q15 - tv)) + 33'd16384;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pu[0] <= bpge_pkg::ONE_Q15;
      qu[0] <= bpge_pkg::ONE_Q15;
      pv[0] <= bpge_pkg::ONE_Q15;
      qv[0] <= bpge_pkg::ONE_Q15;
    end else if (cmd.pow_step) begin
      pu[cmd.pow_k] <= m_pu[30:15];
      qu[cmd.pow_k] <= m_qu[30:15];
      pv[cmd.pow_k] <= m_pv[30:15];
      qv[cmd.pow_k] <= m_qv[30:15];
    end
  end

  // Bernstein weights: product of powers, then binomial scale and cap
  logic [15:0]   wu [bpge_pkg::MAX_SIDE];
  logic [15:0]   wv [bpge_pkg::MAX_SIDE];
  logic [15:0]   prod_u_r, prod_v_r;
  logic [SW-1:0] wi, wim1;
  logic [32:0]   m_wu, m_wv;
  logic [21:0]   c_wu, c_wv;

  assign wi   = cmd.wgt_i[SW-1:0];
  assign wim1 = wi - 1'b1;
  assign m_wu = 33'(pu[wi] * qu[SW'(stat.ncol - wi)]) + 33'd16384;
  assign m_wv = 33'(pv[wi] * qv[SW'(stat.nrow - wi)]) + 33'd16384;
  assign c_wu = 22'(prod_u_r * bpge_pkg::BINOM[stat.ncol][wim1]);
  assign c_wv = 22'(prod_v_r * bpge_pkg::BINOM[stat.nrow][wim1]);

  always_ff @(posedge clk) begin
    if (cmd.wgt_step) begin
      if (!cmd.wgt_i[3]) begin
        prod_u_r <= m_wu[30:15];
        prod_v_r <= m_wv[30:15];
      end
      if (cmd.wgt_i != 4'd0) begin
        wu[wim1] <= (c_wu > 22'(bpge_pkg::ONE_Q15)) ? bpge_pkg::ONE_Q15 : c_wu[15:0];
        wv[wim1] <= (c_wv > 22'(bpge_pkg::ONE_Q15)) ? bpge_pkg::ONE_Q15 : c_wv[15:0];
      end
    end
  end

  // multiply-accumulate pipeline: weight product, coordinate product, sum
  logic [30:0]        wuv_r;
  logic signed [47:0] px_r, py_r;
  logic signed [53:0] ax_r, ay_r;
  logic               v1_r, v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.acc_issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_issue) begin
      wuv_r <= 31'(wu[cmd.acc_i] * wv[cmd.acc_j]);
    end
    if (v1_r) begin
      px_r <= 48'($signed({1'b0, wuv_r}) * $signed(mem_q_r[15:0]));
      py_r <= 48'($signed({1'b0, wuv_r}) * $signed(mem_q_r[31:16]));
    end
    if (cmd.start) begin
      ax_r <= '0;
      ay_r <= '0;
    end else if (v2_r) begin
      ax_r <= ax_r + 54'(px_r);
      ay_r <= ay_r + 54'(py_r);
    end
  end

  // rounding and saturation
  logic               err_r;
  logic signed [53:0] bx, by;
  logic signed [23:0] rx, ry;
  logic signed [15:0] sx, sy;

  always_comb begin
    bx = ax_r + 54'sd536870912;
    by = ay_r + 54'sd536870912;
    rx = 24'(bx >>> 30);
    ry = 24'(by >>> 30);
    sx = (rx > 24'sd32767) ? 16'sh7FFF : (rx < -24'sd32768) ? 16'sh8000 : rx[15:0];
    sy = (ry > 24'sd32767) ? 16'sh7FFF : (ry < -24'sd32768) ? 16'sh8000 : ry[15:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      err_r <= stat.range_err;
    end
    if (cmd.finish) begin
      out_vertex_x <= err_r ? '0 : sx;
      out_vertex_y <= err_r ? '0 : sy;
      out_tex_u    <= err_r ? '0 : tu;
      out_tex_v    <= err_r ? '0 : tv;
      out_status   <= err_r;
    end
  end

endmodule

[rtl/bezier_patch_grid_evaluator.sv]
// Channel | Dir | Handshake              | Payload
// in      | in  | in_valid / in_ready    | opcode, point_index, ctrl_x/y, grid_u/v
// out     | out | out_valid / out_ready  | vertex_x/y, tex_u/v, status
// cfg     | in  | cfg_write_en           | cfg_index, cfg_data
// An evaluation runs 23 division steps, 7 power steps, 9 weight steps, one accumulation step
// per control point, the drain steps and a finish step, which registers its result. An
// out-of-range sample goes straight to the finish step. Reset is synchronous, active low;
// the store is undefined until loaded. A result waiting on out_ready stalls only the next
// finish; loads and new items are taken meanwhile.
// Top level: instantiates bpge_ctrl and bpge_dp; depends on bpge_pkg.
module bezier_patch_grid_evaluator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic [5:0]         in_point_index,
  input  logic signed [15:0] in_ctrl_x,
  input  logic signed [15:0] in_ctrl_y,
  input  logic [7:0]         in_grid_u,
  input  logic [7:0]         in_grid_v,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_vertex_x,
  output logic signed [15:0] out_vertex_y,
  output logic [15:0]        out_tex_u,
  output logic [15:0]        out_tex_v,
  output logic               out_status,
  input  logic               cfg_write_en,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data
);

  bpge_pkg::cmd_t  cmd;
  bpge_pkg::stat_t stat;

  bpge_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bpge_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_point_index (in_point_index),
    .in_ctrl_x      (in_ctrl_x),
    .in_ctrl_y      (in_ctrl_y),
    .in_grid_u      (in_grid_u),
    .in_grid_v      (in_grid_v),
    .out_vertex_x   (out_vertex_x),
    .out_vertex_y   (out_vertex_y),
    .out_tex_u      (out_tex_u),
    .out_tex_v      (out_tex_v),
    .out_status     (out_status)
  );

endmodule

[dv/bpge_vertex_checker.sv]
`timescale 1ns / 1ps
// Checker for the Bezier patch grid evaluator: tracks control point loads and config writes,
// predicts each evaluated vertex and compares it with the result channel. Depends on bpge_pkg.
module bpge_vertex_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_opcode,
  input  logic [5:0]         in_point_index,
  input  logic signed [15:0] in_ctrl_x,
  input  logic signed [15:0] in_ctrl_y,
  input  logic [7:0]         in_grid_u,
  input  logic [7:0]         in_grid_v,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_vertex_x,
  input  logic signed [15:0] out_vertex_y,
  input  logic [15:0]        out_tex_u,
  input  logic [15:0]        out_tex_v,
  input  logic               out_status,
  input  logic               cfg_write_en,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [15:0]        tu;
    logic [15:0]        tv;
    logic               st;
  } vertex_t;

  logic signed [15:0] pt_x [bpge_pkg::DEPTH];
  logic signed [15:0] pt_y [bpge_pkg::DEPTH];
  logic [3:0]         cols_reg;
  logic [3:0]         rows_reg;
  logic [8:0]         res_reg;
  vertex_t            vertex_q [$];

  assign pending = vertex_q.size();

  function automatic int unsigned clampi(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // Q1.15 power by repeated rounded multiplies
  function automatic longint unsigned qpow(longint unsigned b, int unsigned e);
    longint unsigned r;
    r = 32768;
    for (int k = 0; k < e; k++) r = (r * b + 16384) >> 15;
    return r;
  endfunction

  // Bernstein weights for npts points at t, capped at one
  function automatic void weights(longint unsigned t, int unsigned npts,
                                  ref longint unsigned w [bpge_pkg::MAX_SIDE]);
    longint unsigned c;
    longint unsigned v;
    int unsigned n;
    n = npts - 1;
    c = 1;
    for (int unsigned i = 0; i < npts; i++) begin
      if (i > 0) c = c * (n - i + 1) / i;
      v = ((qpow(t, i) * qpow(32768 - t, n - i) + 16384) >> 15) * c;
      w[i] = (v > 32768) ? 32768 : v;
    end
  endfunction

  // round Q.42 sum back to Q4.12 with saturation
  function automatic logic signed [15:0] round_sat(longint acc);
    longint r;
    r = (acc + (64'sd1 <<< 29)) >>> 30;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic vertex_t eval_vertex(int unsigned gu, int unsigned gv);
    vertex_t res;
    int unsigned nc, nr, rs;
    longint unsigned tu, tv;
    longint unsigned wu [bpge_pkg::MAX_SIDE];
    longint unsigned wv [bpge_pkg::MAX_SIDE];
    longint ax, ay, w;
    int unsigned a;
    nc = clampi(cols_reg, 2, bpge_pkg::MAX_SIDE);
    nr = clampi(rows_reg, 2, bpge_pkg::MAX_SIDE);
    rs = clampi(res_reg, 4, 256);
    res = '{vx: 0, vy: 0, tu: 0, tv: 0, st: 1'b1};
    if (gu >= rs || gv >= rs) return res;
    tu = (longint'(gu) * 32768 + (rs - 1) / 2) / (rs - 1);
    tv = (longint'(gv) * 32768 + (rs - 1) / 2) / (rs - 1);
    weights(tu, nc, wu);
    weights(tv, nr, wv);
    ax = 0;
    ay = 0;
    for (int unsigned j = 0; j < nr; j++)
      for (int unsigned i = 0; i < nc; i++) begin
        a = (i + j * nc) % bpge_pkg::DEPTH;
        w = longint'(wu[i] * wv[j]);
        ax += w * longint'(pt_x[a]);
        ay += w * longint'(pt_y[a]);
      end
    res.vx = round_sat(ax);
    res.vy = round_sat(ay);
    res.tu = tu[15:0];
    res.tv = tv[15:0];
    res.st = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin
    vertex_t e;
    if (!rst_n) begin
      cols_reg <= 4'd2;
      rows_reg <= 4'd2;
      res_reg  <= 9'd4;
      fail_count <= 0;
    end else begin
      // config writes
      if (cfg_write_en) begin
        case (cfg_index)
          bpge_pkg::REG_COLS: cols_reg <= cfg_data[3:0];
          bpge_pkg::REG_ROWS: rows_reg <= cfg_data[3:0];
          bpge_pkg::REG_RES:  res_reg  <= cfg_data;
          default: ;
        endcase
      end
      // input transaction
      if (in_valid && in_ready) begin
        if (in_opcode == bpge_pkg::OP_LOAD) begin
          if (in_point_index < clampi(cols_reg, 2, bpge_pkg::MAX_SIDE) *
                               clampi(rows_reg, 2, bpge_pkg::MAX_SIDE)) begin
            pt_x[in_point_index] <= in_ctrl_x;
            pt_y[in_point_index] <= in_ctrl_y;
          end
        end else begin
          vertex_q = {vertex_q, eval_vertex(in_grid_u, in_grid_v)};
        end
      end
      // result transaction
      if (out_valid && out_ready) begin
        if (vertex_q.size() == 0) begin
          $error("unexpected result transaction");
          fail_count <= fail_count + 1;
        end else begin
          e = vertex_q.pop_front();
          if (out_vertex_x !== e.vx || out_vertex_y !== e.vy || out_tex_u !== e.tu ||
              out_tex_v !== e.tv || out_status !== e.st)
            fail_count <= fail_count + 1;
          if (out_vertex_x !== e.vx) $error("vertex_x exp %0d got %0d", e.vx, out_vertex_x);
          if (out_vertex_y !== e.vy) $error("vertex_y exp %0d got %0d", e.vy, out_vertex_y);
          if (out_tex_u !== e.tu) $error("tex_u exp %0d got %0d", e.tu, out_tex_u);
          if (out_tex_v !== e.tv) $error("tex_v exp %0d got %0d", e.tv, out_tex_v);
          if (out_status !== e.st) $error("status exp %0d got %0d", e.st, out_status);
        end
      end
    end
  end

endmodule

[dv/bezier_patch_grid_evaluator_tb.sv]
`timescale 1ns / 1ps
// Top of the Bezier patch grid evaluator testbench: clock, reset, stimulus and verdict.
// Depends on bpge_pkg, bezier_patch_grid_evaluator and bpge_vertex_checker.
module bezier_patch_grid_evaluator_tb;

  localparam int DRAIN_CYCLES = 150;
  localparam int STALL_LIMIT  = 20000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_opcode;
  logic [5:0]         in_point_index;
  logic signed [15:0] in_ctrl_x;
  logic signed [15:0] in_ctrl_y;
  logic [7:0]         in_grid_u;
  logic [7:0]         in_grid_v;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_vertex_x;
  logic signed [15:0] out_vertex_y;
  logic [15:0]        out_tex_u;
  logic [15:0]        out_tex_v;
  logic               out_status;
  logic               cfg_write_en;
  logic [1:0]         cfg_index;
  logic [8:0]         cfg_data;
  int                 fail_count;
  int                 pending;
  int                 idle_pct;
  int                 stall_pct;
  int                 quiet_cycles;
  int unsigned        n_cols;
  int unsigned        n_rows;
  int unsigned        n_res;

  bezier_patch_grid_evaluator dut (.*);
  bpge_vertex_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= stall_pct);

  // watchdog: cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en)
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(logic op, logic [5:0] idx, logic [15:0] x, logic [15:0] y,
                      logic [7:0] u, logic [7:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_point_index <= idx;
    in_ctrl_x      <= x;
    in_ctrl_y      <= y;
    in_grid_u      <= u;
    in_grid_v      <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic eval(logic [7:0] u, logic [7:0] v);
    send(bpge_pkg::OP_EVAL, 6'($urandom), 16'($urandom), 16'($urandom), u, v);
  endtask

  // hold off until idle, then write all three registers (plus a stray index)
  task automatic set_patch(logic [8:0] c, logic [8:0] r, logic [8:0] s);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= bpge_pkg::REG_COLS; cfg_data <= c;
    @(posedge clk);
    cfg_index <= bpge_pkg::REG_ROWS; cfg_data <= r;
    @(posedge clk);
    cfg_index <= bpge_pkg::REG_RES;  cfg_data <= s;
    @(posedge clk);
    cfg_index <= REG_UNUSED;         cfg_data <= 9'($urandom);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    n_cols = (c[3:0] < 2) ? 2 : (c[3:0] > 8) ? 8 : c[3:0];
    n_rows = (r[3:0] < 2) ? 2 : (r[3:0] > 8) ? 8 : r[3:0];
    n_res  = (s < 4) ? 4 : (s > 256) ? 256 : s;
  endtask

  // fill every entry the current patch reads
  task automatic load_patch(logic [15:0] x, logic [15:0] y, bit rnd);
    for (int i = 0; i < n_cols * n_rows; i++)
      send(bpge_pkg::OP_LOAD, 6'(i), rnd ? rand_coord() : x, rnd ? rand_coord() : y,
           8'($urandom), 8'($urandom));
  endtask

  initial begin
    int unsigned g;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = bpge_pkg::OP_LOAD;
    in_point_index = '0;
    in_ctrl_x = '0;
    in_ctrl_y = '0;
    in_grid_u = '0;
    in_grid_v = '0;
    out_ready = 1'b0;
    cfg_write_en = 1'b0;
    cfg_index = bpge_pkg::REG_COLS;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    n_cols = 2; n_rows = 2; n_res = 4;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset sizes, extremes, out-of-range sample, loads outside the patch
    send(bpge_pkg::OP_LOAD, 6'd0, 16'sh7fff, 16'sh8000, 8'd0, 8'd0);
    send(bpge_pkg::OP_LOAD, 6'd1, 16'sh8000, 16'sh7fff, 8'd0, 8'd0);
    send(bpge_pkg::OP_LOAD, 6'd2, 16'sh0000, 16'shffff, 8'd0, 8'd0);
    send(bpge_pkg::OP_LOAD, 6'd3, 16'sh1000, 16'sh1000, 8'd0, 8'd0);
    send(bpge_pkg::OP_LOAD, 6'd4, 16'sh1234, 16'sh1234, 8'd0, 8'd0);
    send(bpge_pkg::OP_LOAD, 6'd63, 16'sh1234, 16'sh1234, 8'd0, 8'd0);
    eval(8'd0, 8'd0); eval(8'd3, 8'd3); eval(8'd1, 8'd2);
    eval(8'd4, 8'd0); eval(8'd0, 8'd4); eval(8'd255, 8'd255);

    // directed: largest patch, full grid, saturation
    set_patch(9'd8, 9'd8, 9'd256);
    load_patch(16'sh7fff, 16'sh8000, 0);
    eval(8'd0, 8'd0); eval(8'd255, 8'd255); eval(8'd128, 8'd127); eval(8'd1, 8'd254);
    set_patch(9'd2, 9'd8, 9'd511);
    eval(8'd255, 8'd0); eval(8'd77, 8'd200);

    // random phases cycling through idling modes
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      case ($urandom_range(0, 3))
        0: set_patch(9'($urandom_range(0, 15)), 9'($urandom_range(0, 15)),
                     9'($urandom_range(0, 511)));
        1: set_patch(9'($urandom_range(2, 8)), 9'($urandom_range(2, 8)), 9'd256);
        default: set_patch(9'($urandom_range(2, 8)), 9'($urandom_range(2, 8)),
                           9'($urandom_range(4, 12)));
      endcase
      load_patch(16'd0, 16'd0, 1);
      for (int k = 0; k < 75; k++) begin
        g = $urandom_range(0, 99);
        if (g < 25)
          send(bpge_pkg::OP_LOAD, 6'($urandom_range(0, 63)), rand_coord(), rand_coord(),
               8'($urandom), 8'($urandom));
        else if (g < 35)
          eval(8'($urandom), 8'($urandom));
        else
          eval(8'($urandom_range(0, n_res - 1)), 8'($urandom_range(0, n_res - 1)));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
